FILE: hw/rtl/cbr_pkg.sv
// Shared types and constants for the circle brush row rasterizer.
package cbr_pkg;

  localparam logic [12:0] FULL_INTENSITY = 13'd4096;
  localparam int STEPS = 18;
  localparam int CNT_W = 5;

  localparam logic [1:0] REG_TEXTURE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_TEXTURE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BRUSH_RADIUS   = 2'd2;
  localparam logic [1:0] REG_LINEAR_FALLOFF = 2'd3;

  typedef struct packed {
    logic        start;
    logic        ack;
    logic [10:0] d2;
    logic [5:0]  radius;
  } falloff_req_t;

  typedef struct packed {
    logic        done;
    logic [12:0] intensity;
  } falloff_rsp_t;

endpackage

FILE: hw/rtl/cbr_falloff.sv
// Iterative falloff engine: ceil sqrt then ceil divide on one shared subtractor.
module cbr_falloff (
  input  logic                   clk,
  input  logic                   rst,
  input  cbr_pkg::falloff_req_t  req,
  output cbr_pkg::falloff_rsp_t  rsp
);

  typedef enum logic [2:0] {
    S_IDLE, S_SQRT, S_ROUND, S_DIV, S_FIN, S_DONE
  } state_t;

  state_t                      state;
  logic [35:0]                 rad;
  logic [17:0]                 q;
  logic [20:0]                 rem;
  logic [cbr_pkg::CNT_W-1:0]   cnt;
  logic [5:0]                  radius;
  logic [12:0]                 intensity;

  logic [20:0] op_a;
  logic [20:0] op_b;
  logic [21:0] diff;
  logic        fits;
  logic        step_last;
  logic [18:0] k_full;
  logic [12:0] k_sat;

  // shared compare/subtract: sqrt trial or divide trial
  always_comb begin
    if (state == S_SQRT) begin
      op_a = {rem[18:0], rad[35:34]};
      op_b = {1'b0, q, 2'b01};
    end else begin
      op_a = {14'd0, rem[5:0], q[17]};
      op_b = {15'd0, radius};
    end
    diff = {1'b0, op_a} - {1'b0, op_b};
    fits = ~diff[21];
  end

  assign step_last = (cnt == cbr_pkg::CNT_W'(cbr_pkg::STEPS - 1));
  assign k_full    = {1'b0, q} + {18'd0, (rem[5:0] != 6'd0)};
  assign k_sat     = (k_full > {6'd0, cbr_pkg::FULL_INTENSITY}) ?
                     cbr_pkg::FULL_INTENSITY : k_full[12:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.start) begin
            rad    <= {1'b0, req.d2, 24'd0};
            q      <= '0;
            rem    <= '0;
            cnt    <= '0;
            radius <= req.radius;
            state  <= S_SQRT;
          end
        end
        S_SQRT: begin
          rem <= fits ? diff[20:0] : op_a;
          q   <= {q[16:0], fits};
          rad <= {rad[33:0], 2'b00};
          cnt <= cnt + 1'b1;
          if (step_last) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          q     <= q + {17'd0, (rem != 21'd0)};
          rem   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= fits ? diff[20:0] : op_a;
          q   <= {q[16:0], fits};
          cnt <= cnt + 1'b1;
          if (step_last) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          intensity <= cbr_pkg::FULL_INTENSITY - k_sat;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (req.ack) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.done      = (state == S_DONE);
  assign rsp.intensity = intensity;

endmodule

FILE: hw/rtl/circle_brush_row_rasterizer_core.sv
// Circle brush row rasterizer top level: row sequencer, config registers, output register.
// Transactions are taken only while idle; then one result per cycle per pixel while the
// output is not stalled and no painted pixel waits on the falloff. A row has 2r pixels.
// Linear: painted pixels wait for 18 sqrt and 18 divide steps of the shared subtractor.
// Synchronous reset sets registers to 1024, 1024, 8, 0 and empties the output.
module circle_brush_row_rasterizer_core #(
  parameter int MAX_RADIUS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [16:0] center_x,
  input  logic signed [16:0] center_y,
  input  logic signed [5:0]  row_offset,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        pixel_x,
  output logic [15:0]        pixel_y,
  output logic               painted,
  output logic [12:0]        intensity,
  output logic               last
);

  typedef enum logic [1:0] {S_IDLE, S_PIXEL, S_WAIT} state_t;

  state_t state;

  logic [15:0] texture_width;
  logic [15:0] texture_height;
  logic [5:0]  brush_radius;
  logic        linear_falloff;

  logic signed [16:0] cx;
  logic signed [17:0] py;
  logic               y_in;
  logic [10:0]        dy2;
  logic [10:0]        r2;
  logic [5:0]         rr;
  logic signed [6:0]  dx;
  logic signed [6:0]  last_dx;
  logic               lin;

  logic [5:0]         r_eff;
  logic signed [17:0] py_in;
  logic signed [11:0] dysq;
  logic [11:0]        rsq;
  logic signed [17:0] px;
  logic               x_in;
  logic signed [13:0] dxsq;
  logic [11:0]        d2;
  logic               paint;
  logic               out_free;
  logic               row_end;
  logic               emit;

  cbr_pkg::falloff_req_t fo_req;
  cbr_pkg::falloff_rsp_t fo_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      texture_width  <= 16'd1024;
      texture_height <= 16'd1024;
      brush_radius   <= 6'd8;
      linear_falloff <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        cbr_pkg::REG_TEXTURE_WIDTH:  texture_width  <= cfg_data;
        cbr_pkg::REG_TEXTURE_HEIGHT: texture_height <= cfg_data;
        cbr_pkg::REG_BRUSH_RADIUS:   brush_radius   <= cfg_data[5:0];
        cbr_pkg::REG_LINEAR_FALLOFF: linear_falloff <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (brush_radius == 6'd0) begin
      r_eff = 6'd1;
    end else if (brush_radius > 6'(MAX_RADIUS)) begin
      r_eff = 6'(MAX_RADIUS);
    end else begin
      r_eff = brush_radius;
    end
    py_in = {center_y[16], center_y} + {{12{row_offset[5]}}, row_offset};
    dysq  = row_offset * row_offset;
    rsq   = {6'd0, r_eff} * {6'd0, r_eff};
  end

  assign px       = {cx[16], cx} + {{11{dx[6]}}, dx};
  assign x_in     = ~px[17] && (px[16:0] < {1'b0, texture_width});
  assign dxsq     = dx * dx;
  assign d2       = {1'b0, dxsq[10:0]} + {1'b0, dy2};
  assign paint    = x_in && y_in && (d2 <= {1'b0, r2});
  assign out_free = !out_valid || out_ready;
  assign row_end  = (dx == last_dx);
  assign in_ready = (state == S_IDLE);
  assign emit     = out_free && (((state == S_PIXEL) && !(paint && lin)) ||
                                 ((state == S_WAIT) && fo_rsp.done));

  assign fo_req.start  = (state == S_PIXEL) && out_free && paint && lin;
  assign fo_req.ack    = (state == S_WAIT) && out_free && fo_rsp.done;
  assign fo_req.d2     = d2[10:0];
  assign fo_req.radius = rr;

  cbr_falloff u_falloff (
    .clk (clk),
    .rst (rst),
    .req (fo_req),
    .rsp (fo_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cx      <= center_x;
            py      <= py_in;
            y_in    <= ~py_in[17] && (py_in[16:0] < {1'b0, texture_height});
            dy2     <= dysq[10:0];
            r2      <= rsq[10:0];
            rr      <= r_eff;
            dx      <= 7'sd0 - $signed({1'b0, r_eff});
            last_dx <= $signed({1'b0, r_eff}) - 7'sd1;
            lin     <= linear_falloff;
            state   <= S_PIXEL;
          end
        end
        S_PIXEL: begin
          if (out_free) begin
            if (paint && lin) begin
              state <= S_WAIT;
            end else begin
              pixel_x   <= paint ? px[15:0] : 16'd0;
              pixel_y   <= paint ? py[15:0] : 16'd0;
              painted   <= paint;
              intensity <= paint ? cbr_pkg::FULL_INTENSITY : 13'd0;
              last      <= row_end;
              dx        <= dx + 7'sd1;
              if (row_end) begin
                state <= S_IDLE;
              end
            end
          end
        end
        S_WAIT: begin
          if (out_free && fo_rsp.done) begin
            pixel_x   <= px[15:0];
            pixel_y   <= py[15:0];
            painted   <= 1'b1;
            intensity <= fo_rsp.intensity;
            last      <= row_end;
            dx        <= dx + 7'sd1;
            state     <= row_end ? S_IDLE : S_PIXEL;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a transaction but stayed ready");

  a_unpainted_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !painted |-> pixel_x == 16'd0 && pixel_y == 16'd0 && intensity == 13'd0)
    else $error("unpainted result carries nonzero payload");

  a_intensity_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> intensity <= cbr_pkg::FULL_INTENSITY)
    else $error("intensity above full scale");

  a_start_to_wait: assert property (@(posedge clk) disable iff (rst)
    fo_req.start |=> state == S_WAIT && !fo_rsp.done)
    else $error("falloff start did not enter wait");

  a_ack_needs_done: assert property (@(posedge clk) disable iff (rst)
    fo_req.ack |-> fo_rsp.done)
    else $error("falloff acknowledged before done");

endmodule
